/* sv/rtph264_pkg.sv */
// Shared types and constants for the RTP H.264 depacketizer.
// Used by the parser, the emitter and the top level; depends on nothing.
package rtph264_pkg;

  // Largest packet length accepted; longer lengths are saturated
  localparam int PACKET_BYTES_MAX_DEF = 65535;

  // Annex B start code, sent in this order
  localparam logic [7:0] START_CODE [4] = '{8'h00, 8'h00, 8'h00, 8'h01};

  // Output beat index within one result group
  localparam int BEAT_W = 3;
  localparam logic [BEAT_W-1:0] BEAT_PREFIX0 = 3'd0;
  localparam logic [BEAT_W-1:0] BEAT_DATA    = 3'd4;

  // Results caused by one input byte
  typedef struct packed {
    logic       prefix;    // send 00 00 00 01 before the byte
    logic       has_byte;  // one result byte present
    logic [7:0] data;      // the result byte
    logic       drop;      // the byte is a dropped-packet flag
  } grp_t;

endpackage

/* sv/rtph264_parser.sv */
// RTP header skip and RFC 6184 payload parser: holds the parse state and
// works out the result group for each accepted byte. Depends on rtph264_pkg.
module rtph264_parser #(
  parameter int PACKET_BYTES_MAX = rtph264_pkg::PACKET_BYTES_MAX_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               go,            // byte accepted this cycle
  input  logic [7:0]         in_byte,
  input  logic               packet_start,
  input  logic [15:0]        packet_bytes,
  output rtph264_pkg::grp_t  grp            // results of the byte on go
);

  localparam int LEFT_W = $clog2(PACKET_BYTES_MAX + 1);
  localparam logic [15:0] LEN_MAX = 16'(PACKET_BYTES_MAX);

  // Parse phases
  localparam logic [3:0] PH_IDLE      = 4'd0;
  localparam logic [3:0] PH_HEADER    = 4'd1;
  localparam logic [3:0] PH_NAL_FIRST = 4'd2;
  localparam logic [3:0] PH_PASS      = 4'd3;
  localparam logic [3:0] PH_LEN_HI    = 4'd4;
  localparam logic [3:0] PH_LEN_LO    = 4'd5;
  localparam logic [3:0] PH_UNIT_HEAD = 4'd6;
  localparam logic [3:0] PH_UNIT_BODY = 4'd7;
  localparam logic [3:0] PH_FU_HEADER = 4'd8;
  localparam logic [3:0] PH_DISCARD   = 4'd9;

  // NAL unit types with special handling
  localparam logic [4:0] NAL_SINGLE_END = 5'd24;
  localparam logic [4:0] NAL_STAP_A     = 5'd24;
  localparam logic [4:0] NAL_FU_A       = 5'd28;

  logic [3:0]        parse_phase, parse_phase_next;
  logic [LEFT_W-1:0] bytes_left, bytes_left_next;
  logic [6:0]        header_bytes_left, header_bytes_left_next;
  logic [LEFT_W-1:0] unit_bytes_left, unit_bytes_left_next;
  logic [7:0]        unit_length_high, unit_length_high_next;
  logic [2:0]        indicator_top_bits, indicator_top_bits_next;

  logic [15:0] len_sat;
  logic [6:0]  hdr_len;
  logic [15:0] unit_len;
  logic [6:0]  hdr_dec;
  logic [LEFT_W-1:0] unit_dec;

  assign len_sat  = (packet_bytes > LEN_MAX) ? LEN_MAX : packet_bytes;
  assign hdr_len  = 7'd12 + {1'b0, in_byte[3:0], 2'b00};
  assign unit_len = {unit_length_high, in_byte};
  assign hdr_dec  = (header_bytes_left != 7'd0) ? header_bytes_left - 7'd1
                                                : header_bytes_left;
  assign unit_dec = unit_bytes_left - LEFT_W'(1);

  // Next parse state and result group for the byte at the input
  always_comb begin
    parse_phase_next        = parse_phase;
    bytes_left_next         = bytes_left;
    header_bytes_left_next  = header_bytes_left;
    unit_bytes_left_next    = unit_bytes_left;
    unit_length_high_next   = unit_length_high;
    indicator_top_bits_next = indicator_top_bits;
    grp                     = '0;

    if (packet_start) begin
      unit_bytes_left_next    = '0;
      unit_length_high_next   = 8'd0;
      indicator_top_bits_next = 3'd0;
      if (len_sat == 16'd0) begin
        parse_phase_next = PH_IDLE;
        bytes_left_next  = '0;
      end else if (len_sat < {9'd0, hdr_len}) begin
        grp.has_byte     = 1'b1;
        grp.drop         = 1'b1;
        parse_phase_next = PH_IDLE;
        bytes_left_next  = '0;
      end else begin
        bytes_left_next        = LEFT_W'(len_sat - 16'd1);
        header_bytes_left_next = hdr_len - 7'd1;
        parse_phase_next       = PH_HEADER;
      end
    end else if (parse_phase != PH_IDLE && bytes_left != '0) begin
      bytes_left_next = bytes_left - LEFT_W'(1);
      unique case (parse_phase)
        PH_HEADER: begin
          header_bytes_left_next = hdr_dec;
          if (hdr_dec == 7'd0) begin
            parse_phase_next = PH_NAL_FIRST;
          end
        end
        PH_NAL_FIRST: begin
          priority if (in_byte[4:0] < NAL_SINGLE_END) begin
            grp.prefix       = 1'b1;
            grp.has_byte     = 1'b1;
            grp.data         = in_byte;
            parse_phase_next = PH_PASS;
          end else if (in_byte[4:0] == NAL_STAP_A) begin
            parse_phase_next = PH_LEN_HI;
          end else if (in_byte[4:0] == NAL_FU_A) begin
            indicator_top_bits_next = in_byte[7:5];
            parse_phase_next        = PH_FU_HEADER;
          end else begin
            parse_phase_next = PH_DISCARD;
          end
        end
        PH_PASS: begin
          grp.has_byte = 1'b1;
          grp.data     = in_byte;
        end
        PH_LEN_HI: begin
          unit_length_high_next = in_byte;
          parse_phase_next      = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          // Overrun ends the packet, zero length is skipped
          priority if (unit_len > 16'(bytes_left_next)) begin
            parse_phase_next = PH_DISCARD;
          end else if (unit_len == 16'd0) begin
            parse_phase_next = PH_LEN_HI;
          end else begin
            unit_bytes_left_next = LEFT_W'(unit_len);
            parse_phase_next     = PH_UNIT_HEAD;
          end
        end
        PH_UNIT_HEAD, PH_UNIT_BODY: begin
          grp.prefix           = (parse_phase == PH_UNIT_HEAD);
          grp.has_byte         = 1'b1;
          grp.data             = in_byte;
          unit_bytes_left_next = unit_dec;
          parse_phase_next     = (unit_dec == '0) ? PH_LEN_HI : PH_UNIT_BODY;
        end
        PH_FU_HEADER: begin
          // Start fragment: rebuild the NAL header from indicator and type
          if (in_byte[7]) begin
            grp.prefix   = 1'b1;
            grp.has_byte = 1'b1;
            grp.data     = {indicator_top_bits, in_byte[4:0]};
          end
          parse_phase_next = PH_PASS;
        end
        default: begin
        end
      endcase
    end

    if (bytes_left_next == '0) begin
      parse_phase_next = PH_IDLE;
    end
  end

  // Advance the parse state on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase        <= PH_IDLE;
      bytes_left         <= '0;
      header_bytes_left  <= 7'd0;
      unit_bytes_left    <= '0;
      unit_length_high   <= 8'd0;
      indicator_top_bits <= 3'd0;
    end else if (go) begin
      parse_phase        <= parse_phase_next;
      bytes_left         <= bytes_left_next;
      header_bytes_left  <= header_bytes_left_next;
      unit_bytes_left    <= unit_bytes_left_next;
      unit_length_high   <= unit_length_high_next;
      indicator_top_bits <= indicator_top_bits_next;
    end
  end

endmodule

/* sv/rtph264_emitter.sv */
// Result register and beat sequencer: holds one result group and sends
// its start code and data byte as output beats. Depends on rtph264_pkg.
module rtph264_emitter (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,      // take a new group this cycle
  input  rtph264_pkg::grp_t grp_in,
  output logic              free,      // group can be replaced this cycle
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata,
  output logic [1:0]        m_tuser,
  output logic              m_tlast
);

  rtph264_pkg::grp_t                grp;
  logic                             busy;
  logic [rtph264_pkg::BEAT_W-1:0]   beat;
  logic                             last_beat;
  logic                             fire;

  assign last_beat = (beat == rtph264_pkg::BEAT_DATA);
  assign fire      = busy && m_tready;
  assign free      = !busy || (fire && last_beat);

  // Drive the current beat
  assign m_tvalid   = busy;
  assign m_tdata    = last_beat ? grp.data : rtph264_pkg::START_CODE[beat[1:0]];
  assign m_tuser[0] = !last_beat;
  assign m_tuser[1] = last_beat && grp.drop;
  assign m_tlast    = last_beat;

  // Hold the group and step through its beats
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      beat <= rtph264_pkg::BEAT_DATA;
    end else if (load) begin
      busy <= 1'b1;
      beat <= grp_in.prefix ? rtph264_pkg::BEAT_PREFIX0 : rtph264_pkg::BEAT_DATA;
    end else if (fire) begin
      if (last_beat) begin
        busy <= 1'b0;
      end else begin
        beat <= beat + {{(rtph264_pkg::BEAT_W-1){1'b0}}, 1'b1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp <= grp_in;
    end
  end

endmodule

/* sv/rtp_h264_depacketizer.sv */
// RTP H.264 depacketizer: RTP packet bytes in, Annex B byte stream out.
// The first output beat of a byte comes from the result register the cycle after it is taken.
// Throughput: one byte per cycle while m_tready is high; a byte that opens a NAL unit
// sends five beats (start code plus byte) and holds the input until its data beat is taken.
// Reset: synchronous rst clears the parse state and empties the result register.
// Depends on rtph264_pkg, rtph264_parser and rtph264_emitter.
module rtp_h264_depacketizer #(
  parameter int PACKET_BYTES_MAX = rtph264_pkg::PACKET_BYTES_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [7:0] in_byte, [23:8] packet_bytes
  input  logic        s_tuser,   // [0] packet_start
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  output logic [1:0]  m_tuser,   // [0] start_code_byte, [1] header_drop
  output logic        m_tlast    // run_last
);

  rtph264_pkg::grp_t grp;
  logic              go;
  logic              free;

  assign s_tready = free;
  assign go       = s_tvalid && s_tready;

  rtph264_parser #(
    .PACKET_BYTES_MAX(PACKET_BYTES_MAX)
  ) u_parser (
    .clk          (clk),
    .rst          (rst),
    .go           (go),
    .in_byte      (s_tdata[7:0]),
    .packet_start (s_tuser),
    .packet_bytes (s_tdata[23:8]),
    .grp          (grp)
  );

  // Load only bytes that cause results
  rtph264_emitter u_emitter (
    .clk      (clk),
    .rst      (rst),
    .load     (go && grp.has_byte),
    .grp_in   (grp),
    .free     (free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

/* sv/rtph264_checker.sv */
// Port-level checks for the RTP H.264 depacketizer, bound to the top level.
// Depends only on the ports of rtp_h264_depacketizer.
module rtph264_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);

  // Stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                              && $stable(m_tlast))
    else $error("output beat changed while stalled");

  // Drop flag is a lone zero beat
  a_drop_beat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tlast && m_tdata == 8'd0 && !m_tuser[0])
    else $error("malformed drop beat");

  // Start code never ends a run
  a_prefix_not_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> !m_tlast)
    else $error("start code beat marked last");

  // Data byte follows the final start code byte
  a_prefix_then_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tuser[0] && m_tdata == 8'd1 |=> m_tvalid && !m_tuser[0])
    else $error("no data byte after start code");

  // Empty output side always takes input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

endmodule

bind rtp_h264_depacketizer rtph264_checker u_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
